### hw/rtl/mbps_pkg.sv
// Shared constants, types and register codes for the masked byte pattern search.
package mbps_pkg;

  // Pattern geometry
  localparam int PATTERN_MAX = 32;
  localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
  localparam int LEN_W       = 6;
  localparam int PAT_REGS    = 4;
  localparam int BYTES_PER_REG = 8;

  // Byte counter and result widths
  localparam int COUNT_BITS = 32;
  localparam int OFF_W      = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CARE_W     = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CARE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd5;

  typedef logic [7:0] byte_t;

  // Pattern realigned by window age: entry a is compared against the byte of age a
  typedef struct packed {
    byte_t [PATTERN_MAX-1:0] apat;
    logic  [PATTERN_MAX-1:0] acare;
    logic  [LEN_W-1:0]       len;
    logic                    len_ok;
  } cfg_t;

  // Result of one processed item
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [OFF_W-1:0] offset;
  } res_t;

endpackage

### hw/rtl/mbps_cfg_regs.sv
// Configuration registers and age-aligned view of the pattern.
module mbps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mbps_pkg::cfg_t                   cfg
);
  import mbps_pkg::*;

  logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pat_r;
  logic [CARE_W-1:0]                   care_r;
  logic [LEN_W-1:0]                    len_r;
  byte_t [PATTERN_MAX-1:0]             pat_bytes;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      care_r <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT0: pat_r[0] <= cfg_wdata;
        REG_PAT1: pat_r[1] <= cfg_wdata;
        REG_PAT2: pat_r[2] <= cfg_wdata;
        REG_PAT3: pat_r[3] <= cfg_wdata;
        REG_CARE: care_r   <= cfg_wdata[CARE_W-1:0];
        REG_LEN:  len_r    <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_r;

  // Realign: pattern byte j = len-1-a sits at window age a
  always_comb begin
    logic [LEN_W-1:0] j;
    cfg.len    = len_r;
    cfg.len_ok = (len_r != '0) && (len_r <= LEN_W'(PATTERN_MAX));
    for (int a = 0; a < PATTERN_MAX; a++) begin
      j = len_r - LEN_W'(1) - LEN_W'(a);
      cfg.apat[a]  = pat_bytes[j[PAT_IDX_W-1:0]];
      cfg.acare[a] = (LEN_W'(a) < len_r) && care_r[j[PAT_IDX_W-1:0]];
    end
  end

endmodule

### hw/rtl/mbps_core.sv
// Byte window, buffer byte count and masked window compare.
module mbps_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  mbps_pkg::byte_t data_byte,
  input  logic            last_byte,
  input  mbps_pkg::cfg_t  cfg,
  output mbps_pkg::res_t  res
);
  import mbps_pkg::*;

  // Window entries older than the byte count are never compared, so no reset
  byte_t [PATTERN_MAX-1:0] window_r;
  byte_t [PATTERN_MAX-1:0] window_nxt;
  logic [COUNT_BITS-1:0]   seen_r, seen_nxt, seen_inc;
  logic                    reported_r, reported_nxt;
  logic [PATTERN_MAX-1:0]  pos_ok;
  logic                    counted, enough, hit;

  assign window_nxt = {window_r[PATTERN_MAX-2:0], data_byte};
  assign seen_inc   = seen_r + COUNT_BITS'(1);
  assign counted    = (seen_r != '1);
  assign enough     = (seen_inc >= COUNT_BITS'(cfg.len));

  // Per-position masked compare
  always_comb begin
    for (int a = 0; a < PATTERN_MAX; a++) begin
      pos_ok[a] = !cfg.acare[a] || (window_nxt[a] == cfg.apat[a]);
    end
  end

  assign hit = counted && !reported_r && cfg.len_ok && enough && (&pos_ok);

  // Result for this item
  always_comb begin
    res.valid  = hit || (last_byte && !reported_r);
    res.found  = hit;
    res.offset = hit ? OFF_W'(seen_inc - COUNT_BITS'(cfg.len)) : '0;
  end

  // Advance the buffer state; restart on the last byte
  always_comb begin
    if (last_byte) begin
      seen_nxt     = '0;
      reported_nxt = 1'b0;
    end else begin
      seen_nxt     = counted ? seen_inc : seen_r;
      reported_nxt = reported_r || hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else if (step) begin
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      window_r <= window_nxt;
    end
  end

  a_reported_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> (seen_r != '0))
    else $error("match reported with empty byte count");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> (seen_r == '0) && !reported_r)
    else $error("buffer state not restarted after last byte");

  a_single_report: assert property (@(posedge clk) disable iff (!rst_n)
    reported_r |-> !hit)
    else $error("second match reported in one buffer");

endmodule

### hw/rtl/masked_byte_pattern_search.sv
// Top level: input stage, search core and result register.
// An accepted item waits in the input register; its result is then held in the result register.
// Throughput: one byte per cycle while the result register is not stalled.
// A stalled result register holds the input stage; an item that makes no result still needs it free.
// Reset (rst_n, synchronous, active low) clears configuration, byte count, match flag and valids.
// The byte window is not cleared; its entries are only compared once filled by the current buffer.
module masked_byte_pattern_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [mbps_pkg::OFF_W-1:0]          out_match_offset,
  input  logic                                cfg_we,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mbps_pkg::*;

  cfg_t  cfg;
  res_t  res;
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  s1_last_r;
  logic  s1_adv;
  logic  out_valid_r, out_valid_nxt;
  logic  out_found_r;
  logic [OFF_W-1:0] out_offset_r;

  mbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  // Stage advances when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = (s1_adv && res.valid) || (out_valid_r && !out_ready);

  // Hold the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      out_found_r  <= res.found;
      out_offset_r <= res.offset;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_offset_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input stage dropped an item while result stalled");

  a_not_found_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && res.valid && !res.found |-> s1_last_r)
    else $error("not-found result on a byte other than the last");

  a_not_found_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> (out_offset_r == '0))
    else $error("not-found result with nonzero offset");

endmodule

### tb/testbench.sv
// Testbench for masked_byte_pattern_search: directed and random byte buffers checked by a predictor.
`timescale 1ns / 100ps

module testbench;
  import mbps_pkg::*;

  // Result as seen on the output channel
  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } search_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = '0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_found;
  logic [OFF_W-1:0]      out_match_offset;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of configuration and search state
  logic [CFG_DATA_W-1:0] search_pat [PAT_REGS];
  logic [CARE_W-1:0]     search_care;
  logic [LEN_W-1:0]      search_len;
  byte_t                 hist_window [PATTERN_MAX];
  logic [COUNT_BITS-1:0] seen_count;
  bit                    match_flag;

  search_result_t expected_results [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  masked_byte_pattern_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic byte_t pat_byte(input int j);
    return search_pat[2'((j >> 3) & 3)][(j & 7) * 8 +: 8];
  endfunction

  function automatic void clear_search_state();
    foreach (hist_window[i]) hist_window[i] = '0;
    seen_count = '0;
    match_flag = 1'b0;
  endfunction

  // Append one expected result to the tail of the queue
  function automatic void queue_expected(input search_result_t r);
    expected_results = {expected_results, r};
  endfunction

  // Advance the search by one byte and queue the result it causes, if any
  function automatic void predict_search(input byte_t b, input bit last);
    bit hit;
    bit emitted;
    emitted = 1'b0;
    for (int i = PATTERN_MAX - 1; i > 0; i--) hist_window[i] = hist_window[i-1];
    hist_window[0] = b;
    if (seen_count != '1) begin
      seen_count++;
      if (!match_flag && search_len >= 1 && search_len <= PATTERN_MAX &&
          seen_count >= search_len) begin
        hit = 1'b1;
        for (int j = 0; j < search_len; j++) begin
          if (search_care[j] &&
              hist_window[PAT_IDX_W'(search_len - 1 - j)] != pat_byte(j)) hit = 1'b0;
        end
        if (hit) begin
          match_flag = 1'b1;
          emitted = 1'b1;
          queue_expected('{1'b1, OFF_W'(seen_count - search_len)});
        end
      end
    end
    if (last) begin
      if (!match_flag && !emitted) queue_expected('{1'b0, '0});
      clear_search_state();
    end
  endfunction

  // Send one item; returns at the edge where it is accepted with valid still high
  task automatic send_byte(input byte_t b, input bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    predict_search(b, last);
  endtask

  task automatic send_stream(input byte_t stream_q [$]);
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CARE) search_care = data[CARE_W-1:0];
    else if (idx == REG_LEN) search_len = data[LEN_W-1:0];
    else if (idx <= REG_PAT3) search_pat[idx[1:0]] = data;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] word0, input logic [CARE_W-1:0] care,
                           input int len);
    quiesce();
    write_reg(REG_PAT0, word0);
    write_reg(REG_CARE, {32'h0, care});
    write_reg(REG_LEN, CFG_DATA_W'(len));
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (err_count < 10)
          $display("unexpected result: found=%0b offset=%0d", out_found, out_match_offset);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_found !== want.found || out_match_offset !== want.offset) begin
          if (err_count < 10)
            $display("mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                     want.found, want.offset, out_found, out_match_offset);
          err_count++;
        end
      end
    end
  end

  // Empty pattern, wildcards, short buffers, suppressed rematches, overlong length
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // empty pattern after reset never matches
    send_stream('{8'h00, 8'hFF});
    // "AB" plus a wildcard; match lands on the last byte
    configure(64'h4241, 32'b011, 3);
    send_stream('{8'h41, 8'h42, 8'h7E});
    // buffer shorter than the pattern
    send_stream('{8'h41, 8'h42});
    // early match; the later one and the last byte give nothing
    send_stream('{8'h41, 8'h42, 8'h00, 8'h41, 8'h42, 8'hFF});
    // overlong length, then switch mid-buffer; the window keeps its byte
    configure(64'h4241, 32'h0, PATTERN_MAX + 1);
    send_byte(8'h5A, 1'b0);
    configure(64'hA55A, 32'b11, 2);
    send_byte(8'hA5, 1'b1);
    // match at a nonzero offset
    send_stream('{8'h00, 8'hFF, 8'h5A, 8'hA5});
    // single wildcard matches the first byte of any buffer
    configure(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1);
    send_stream('{8'hFF});
    quiesce();
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic randomize_search_config();
    logic [CFG_DATA_W-1:0] data;
    int len_v;
    case ($urandom_range(9))
      0: len_v = 0;
      1: len_v = 1;
      2: len_v = PATTERN_MAX;
      3: len_v = $urandom_range(PATTERN_MAX + 1, 63);
      default: len_v = $urandom_range(2, 8);
    endcase
    quiesce();
    for (int r = 0; r < PAT_REGS; r++) write_reg(REG_PAT0 + CFG_IDX_W'(r), pick_word());
    data = {$urandom, $urandom};
    case ($urandom_range(3))
      0: data[CARE_W-1:0] = '0;
      1: data[CARE_W-1:0] = '1;
      default: data[CARE_W-1:0] = $urandom;
    endcase
    write_reg(REG_CARE, data);
    data = {$urandom, $urandom};
    data[LEN_W-1:0] = LEN_W'(len_v);
    write_reg(REG_LEN, data);
  endtask

  // One buffer: mostly a planted pattern among pattern-like bytes, some noise
  task automatic send_random_buffer(output int sent);
    byte_t stream_q [$];
    int kind, n, at;
    kind = $urandom_range(99);
    n = (kind < 10) ? $urandom_range(1, 3) : $urandom_range(1, 16) + int'(search_len);
    if (n > 48) n = 48;
    for (int i = 0; i < n; i++)
      stream_q = {stream_q,
                  ((kind < 50) ? pat_byte($urandom_range(PATTERN_MAX - 1)) : byte_t'($urandom))};
    if (kind >= 25 && search_len >= 1 && search_len <= PATTERN_MAX && n >= search_len) begin
      at = $urandom_range(n - search_len);
      for (int j = 0; j < search_len; j++)
        stream_q[at + j] = search_care[j] ? pat_byte(j) : byte_t'($urandom);
      // break the planted copy now and then
      if (kind < 35) stream_q[at + $urandom_range(search_len - 1)] ^= 8'h01 << $urandom_range(7);
    end
    send_stream(stream_q);
    sent = n;
  endtask

  task automatic test_random_buffers();
    int sent, total;
    int idle_set [4] = '{0, 50, 0, 28};
    int stall_set [4] = '{0, 0, 50, 28};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_set[p];
      recv_stall_pct = stall_set[p];
      repeat (3) begin
        randomize_search_config();
        total = 0;
        while (total < 40) begin
          send_random_buffer(sent);
          total += sent;
        end
      end
    end
    quiesce();
  endtask

  // Hold the receiver off while one-byte buffers keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure('0, 32'h0, 1);
    @(posedge clk);
    hold_cycles = 150;
    repeat (30) send_byte(byte_t'($urandom), 1'b1);
    quiesce();
  endtask

  initial begin
    foreach (search_pat[r]) search_pat[r] = '0;
    search_care = '0;
    search_len  = '0;
    clear_search_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_buffers();
    test_output_backpressure();

    repeat (10) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_cfg_regs.sv
hw/rtl/mbps_core.sv
hw/rtl/masked_byte_pattern_search.sv
tb/testbench.sv
